[rtl/pgwt_pkg.sv]
// Shared types for the page generation write tracker.
// Item structs, operation codes and the front-to-back command control word.
`default_nettype none
package pgwt_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_RESET    = 2'd0,
    OP_REGISTER = 2'd1,
    OP_WRITE    = 2'd2,
    OP_PAIR     = 2'd3
  } pgwt_op_e;

  // Command kinds carried from front to back
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_PAIR  = 2'd2
  } pgwt_cmd_e;

  localparam logic [31:0] ADDR_MASK = 32'h1FFF_FFFF;
  localparam logic [63:0] GEN_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] length;
    logic        drop_watches;
    logic [31:0] exec_pc;
    logic        last_pair;
  } pgwt_in_t;

  typedef struct packed {
    logic        cacheable;
    logic [63:0] cache_epoch;
    logic [63:0] generation_sum;
  } pgwt_out_t;

  // Control part of a command; page bounds travel beside it
  typedef struct packed {
    pgwt_cmd_e kind;
    logic      clr_watch;  // clear: also clear watch bits
    logic      walk;       // write/pair: walk the page range
    logic      last_pair;  // pair: answer after this one
    logic      query_ok;   // pair: query valid and covered something
  } pgwt_ctl_t;

endpackage
`default_nettype wire

[rtl/pgwt_cmd_fifo.sv]
// Two-entry command queue between front and back.
// Generic width; no package dependency.
`default_nettype none
module pgwt_cmd_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_q, wr_d, rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

[rtl/pgwt_front.sv]
// Front end: accepts items, holds the image window and query validity,
// and turns each item into a page-range command. Uses pgwt_pkg.
`default_nettype none
module pgwt_front #(
  parameter int PAGE_SHIFT = 12,
  parameter int PAGE_COUNT = 512,
  parameter int PGW        = $clog2(PAGE_COUNT)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire pgwt_pkg::pgwt_in_t in_i,
  output pgwt_pkg::pgwt_ctl_t    ctl_o,
  output logic [PGW-1:0]         first_o,
  output logic [PGW-1:0]         last_o
);
  import pgwt_pkg::*;

  localparam int unsigned RAM_BYTES = PAGE_COUNT << PAGE_SHIFT;
  localparam int          AW        = $clog2(RAM_BYTES) + 1;
  localparam logic [31:0] RAM32     = 32'(RAM_BYTES);

  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic          reg_q, reg_d, fail_q, fail_d, any_q, any_d;

  // Register operation
  logic          in_ram;
  logic [AW-1:0] room, len_clip;
  // Write operation
  logic [32:0]   w_end33;
  logic [AW-1:0] w_end, w_lo, w_hi, w_hm1;
  logic          w_walk;
  // Query pair
  logic [31:0]   phys, at, p_end, p_start, p_em1, hi32;
  logic          p_bad, p_walk, p_fail, p_any;

  always_comb begin
    in_ram   = in_i.address < RAM32;
    room     = AW'(RAM_BYTES) - in_i.address[AW-1:0];
    len_clip = (in_i.length > 32'(room)) ? room : in_i.length[AW-1:0];

    w_end33 = {1'b0, in_i.address} + {1'b0, in_i.length};
    w_end   = (w_end33 > {1'b0, RAM32}) ? AW'(RAM_BYTES) : w_end33[AW-1:0];
    w_lo    = (in_i.address[AW-1:0] < lo_q) ? lo_q : in_i.address[AW-1:0];
    w_hi    = (w_end > hi_q) ? hi_q : w_end;
    w_hm1   = w_hi - AW'(1);
    w_walk  = reg_q && (in_i.length != 32'd0) && in_ram && (w_hi > w_lo);

    phys    = in_i.address & ADDR_MASK;
    at      = in_i.exec_pc & ADDR_MASK;
    hi32    = 32'(hi_q);
    p_bad   = !reg_q || (in_i.length == 32'd0) || (phys < 32'(lo_q)) ||
              (phys >= hi32) || (in_i.length > (hi32 - phys));
    p_end   = phys + in_i.length;
    p_start = (phys < at) ? at : phys;
    p_em1   = p_end - 32'd1;
    p_fail  = fail_q || p_bad;
    p_walk  = !p_fail && (p_end > at);
    p_any   = any_q || p_walk;
  end

  // Command build and window state update
  always_comb begin
    lo_d   = lo_q;
    hi_d   = hi_q;
    reg_d  = reg_q;
    fail_d = fail_q;
    any_d  = any_q;
    ctl_o.kind      = CMD_CLEAR;
    ctl_o.clr_watch = in_i.drop_watches;
    ctl_o.walk      = 1'b0;
    ctl_o.last_pair = in_i.last_pair;
    ctl_o.query_ok  = !p_fail && p_any;
    first_o = PGW'(w_lo >> PAGE_SHIFT);
    last_o  = PGW'(w_hm1 >> PAGE_SHIFT);
    unique case (pgwt_op_e'(in_i.operation))
      OP_RESET: begin
        ctl_o.kind = CMD_CLEAR;
      end
      OP_REGISTER: begin
        ctl_o.kind      = CMD_CLEAR;
        ctl_o.clr_watch = 1'b1;
        if (in_ram) begin
          lo_d  = in_i.address[AW-1:0];
          hi_d  = in_i.address[AW-1:0] + len_clip;
          reg_d = len_clip != '0;
        end else begin
          lo_d  = '0;
          hi_d  = '0;
          reg_d = 1'b0;
        end
      end
      OP_WRITE: begin
        ctl_o.kind = CMD_WRITE;
        ctl_o.walk = w_walk;
      end
      OP_PAIR: begin
        ctl_o.kind = CMD_PAIR;
        ctl_o.walk = p_walk;
        first_o    = PGW'(p_start >> PAGE_SHIFT);
        last_o     = PGW'(p_em1 >> PAGE_SHIFT);
        fail_d     = in_i.last_pair ? 1'b0 : p_fail;
        any_d      = in_i.last_pair ? 1'b0 : p_any;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      hi_q   <= '0;
      reg_q  <= 1'b0;
      fail_q <= 1'b0;
      any_q  <= 1'b0;
    end else if (accept_i) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      reg_q  <= reg_d;
      fail_q <= fail_d;
      any_q  <= any_d;
    end
  end
endmodule
`default_nettype wire

[rtl/pgwt_back.sv]
// Back end: page memories, epoch, clearing sweep, page walks and result
// register. Uses pgwt_pkg.
`default_nettype none
module pgwt_back #(
  parameter int PAGE_COUNT = 512,
  parameter int PGW        = $clog2(PAGE_COUNT)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire pgwt_pkg::pgwt_ctl_t ctl_i,
  input  wire logic [PGW-1:0]     first_i,
  input  wire logic [PGW-1:0]     last_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pgwt_pkg::pgwt_out_t     out_o
);
  import pgwt_pkg::*;

  typedef enum logic [4:0] {
    ST_SWEEP  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_RD     = 5'b00100,
    ST_UPD    = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  pgwt_ctl_t      cmd_q, cmd_d;
  logic [PGW-1:0] pg_q, pg_d, last_q, last_d;
  logic           clr_q, clr_d;
  logic [63:0]    epoch_q, epoch_d, sum_q, sum_d;
  logic           dis_q, dis_d, rep_q, rep_d;
  logic           ovalid_q, ovalid_d;
  pgwt_out_t      out_q, out_d;
  logic           load_out;

  logic [63:0]    gen_mem [PAGE_COUNT];
  logic           watch_mem [PAGE_COUNT];
  logic [63:0]    gen_rd_q, gen_wdata;
  logic           watch_rd_q, watch_wdata, gen_we, watch_we;
  logic [64:0]    sum_add;
  logic           result_ok;

  assign sum_add   = {1'b0, sum_q} + {1'b0, gen_rd_q};
  assign result_ok = cmd_q.query_ok && rep_q && !dis_q;
  assign load_out  = !ovalid_q || !out_stall_i;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    pg_d    = pg_q;
    last_d  = last_q;
    clr_d   = clr_q;
    epoch_d = epoch_q;
    sum_d   = sum_q;
    dis_d   = dis_q;
    rep_d   = rep_q;
    ovalid_d = ovalid_q && out_stall_i;
    out_d    = out_q;
    gen_we      = 1'b0;
    watch_we    = 1'b0;
    gen_wdata   = '0;
    watch_wdata = 1'b0;
    unique case (state_q)
      ST_SWEEP: begin
        gen_we   = 1'b1;
        watch_we = clr_q;
        pg_d     = pg_q + PGW'(1);
        if (32'(pg_q) == 32'(PAGE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          cmd_d  = ctl_i;
          pg_d   = first_i;
          last_d = last_i;
          clr_d  = ctl_i.clr_watch;
          unique case (ctl_i.kind)
            CMD_CLEAR: begin
              pg_d = '0;
              if (epoch_q == GEN_MAX) begin
                dis_d = 1'b1;
              end else begin
                epoch_d = epoch_q + 64'd1;
                dis_d   = 1'b0;
              end
              state_d = ST_SWEEP;
            end
            CMD_WRITE: state_d = ctl_i.walk ? ST_RD : ST_IDLE;
            CMD_PAIR: begin
              if (ctl_i.walk) state_d = ST_RD;
              else if (ctl_i.last_pair) state_d = ST_RESULT;
              else state_d = ST_IDLE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (cmd_q.kind == CMD_WRITE) begin
          if (watch_rd_q) begin
            if (gen_rd_q == GEN_MAX) begin
              dis_d = 1'b1;
            end else begin
              gen_we    = 1'b1;
              gen_wdata = gen_rd_q + 64'd1;
            end
          end
        end else begin
          watch_we    = 1'b1;
          watch_wdata = 1'b1;
          if (sum_add[64]) rep_d = 1'b0;
          else sum_d = sum_add[63:0];
        end
        pg_d = pg_q + PGW'(1);
        if (pg_q == last_q) begin
          state_d = ((cmd_q.kind == CMD_PAIR) && cmd_q.last_pair) ? ST_RESULT : ST_IDLE;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RESULT: begin
        if (load_out) begin
          ovalid_d = 1'b1;
          out_d.cacheable      = result_ok;
          out_d.cache_epoch    = result_ok ? epoch_q : 64'd0;
          out_d.generation_sum = result_ok ? sum_q : 64'd0;
          sum_d   = '0;
          rep_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SWEEP;
      pg_q     <= '0;
      clr_q    <= 1'b1;
      epoch_q  <= 64'd1;
      dis_q    <= 1'b0;
      sum_q    <= '0;
      rep_q    <= 1'b1;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pg_q     <= pg_d;
      clr_q    <= clr_d;
      epoch_q  <= epoch_d;
      dis_q    <= dis_d;
      sum_q    <= sum_d;
      rep_q    <= rep_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  // Generation memory
  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[pg_q] <= gen_wdata;
    end
    gen_rd_q <= gen_mem[pg_q];
  end

  // Watch bit memory
  always_ff @(posedge clk_i) begin
    if (watch_we) begin
      watch_mem[pg_q] <= watch_wdata;
    end
    watch_rd_q <= watch_mem[pg_q];
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  // Checks
  a_rd_then_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_UPD)) else $error("read not followed by update");
  a_zero_when_uncacheable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_q.cacheable) |-> (out_q.cache_epoch == 64'd0 &&
      out_q.generation_sum == 64'd0)) else $error("uncacheable result not zero");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && ovalid_q && out_stall_i) |=> (state_q == ST_RESULT))
    else $error("result dropped while output stalled");
endmodule
`default_nettype wire

[rtl/page_generation_write_tracker.sv]
// Page generation write tracker top level: front, command queue, back.
// A final query pair answers through the queue pop, a read and an update step
// per covered page and the result register. The back end is busy with a
// write or pair for its page walk, and with a reset or register item for
// a sweep of the page memories. After reset the back end clears both
// memories in a sweep; the queue takes two items.
`default_nettype none
module page_generation_write_tracker #(
  parameter int PAGE_SHIFT = 12,
  parameter int PAGE_COUNT = 512
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pgwt_pkg::pgwt_in_t in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pgwt_pkg::pgwt_out_t     out_o
);
  import pgwt_pkg::*;

  localparam int PGW = $clog2(PAGE_COUNT);
  localparam int CW  = $bits(pgwt_ctl_t) + 2 * PGW;

  pgwt_ctl_t      f_ctl, b_ctl;
  logic [PGW-1:0] f_first, f_last, b_first, b_last;
  logic           full, empty, pop, accept;
  logic [CW-1:0]  q_out;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  pgwt_front #(.PAGE_SHIFT(PAGE_SHIFT), .PAGE_COUNT(PAGE_COUNT), .PGW(PGW)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .in_i,
    .ctl_o(f_ctl), .first_o(f_first), .last_o(f_last)
  );

  pgwt_cmd_fifo #(.W(CW)) u_fifo (
    .clk_i, .rst_ni, .push_i(accept), .data_i({f_ctl, f_first, f_last}),
    .full_o(full), .pop_i(pop), .data_o(q_out), .empty_o(empty)
  );

  assign {b_ctl, b_first, b_last} = q_out;

  pgwt_back #(.PAGE_COUNT(PAGE_COUNT), .PGW(PGW)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .ctl_i(b_ctl), .first_i(b_first),
    .last_i(b_last), .pop_o(pop), .out_valid_o, .out_stall_i, .out_o
  );
endmodule
`default_nettype wire

[bench/pgwt_result_checker.sv]
// Result checker for the page generation write tracker testbench.
// Watches both channels, models the tracker state and compares each answer.
// Depends on pgwt_pkg for the item structs and operation codes.
`timescale 1ns / 100ps
module pgwt_result_checker #(
  parameter int PAGE_SHIFT = 12,
  parameter int PAGE_COUNT = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  pgwt_pkg::pgwt_in_t  in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  pgwt_pkg::pgwt_out_t out_i,
  output int                  fail_count_o,
  output int                  pending_count_o,
  output int                  answer_count_o
);
  import pgwt_pkg::*;

  localparam longint unsigned RAM_BYTES = longint'(PAGE_COUNT) << PAGE_SHIFT;

  // Model state
  bit          watched[PAGE_COUNT];
  logic [63:0] page_gen[PAGE_COUNT];
  logic [63:0] epoch;
  logic [31:0] win_lo, win_hi;
  bit          win_valid, disabled;
  logic [63:0] run_sum;
  bit          q_any, q_repr, q_failed;

  pgwt_out_t   pending_answers[$];

  assign pending_count_o = pending_answers.size();

  function automatic void clear_query();
    run_sum  = '0;
    q_any    = 1'b0;
    q_repr   = 1'b1;
    q_failed = 1'b0;
  endfunction

  function automatic void restart_image(bit clr);
    if (epoch == GEN_MAX) disabled = 1'b1;
    else begin
      epoch    = epoch + 64'd1;
      disabled = 1'b0;
    end
    foreach (page_gen[p]) begin
      page_gen[p] = '0;
      if (clr) watched[p] = 1'b0;
    end
  endfunction

  function automatic void set_window(logic [31:0] addr, logic [31:0] len);
    if (longint'(addr) >= RAM_BYTES) begin
      win_lo    = '0;
      win_hi    = '0;
      win_valid = 1'b0;
    end else begin
      if (longint'(len) > RAM_BYTES - addr) len = 32'(RAM_BYTES - addr);
      win_lo    = addr;
      win_hi    = addr + len;
      win_valid = len != 0;
    end
    restart_image(1'b1);
  endfunction

  // Bump generations of watched pages touched by a clipped write
  function automatic void note_write(logic [31:0] addr, logic [31:0] len);
    longint unsigned stop, lo, hi;
    int              p, last;
    if (!win_valid || len == 0 || longint'(addr) >= RAM_BYTES) return;
    stop = longint'(addr) + len;
    if (stop > RAM_BYTES) stop = RAM_BYTES;
    lo = (addr < win_lo) ? win_lo : addr;
    hi = (stop > win_hi) ? win_hi : stop;
    if (hi <= lo) return;
    last = int'((hi - 1) >> PAGE_SHIFT);
    for (p = int'(lo >> PAGE_SHIFT); p <= last && p < PAGE_COUNT; p++) begin
      if (!watched[p]) continue;
      if (page_gen[p] == GEN_MAX) disabled = 1'b1;
      else page_gen[p] = page_gen[p] + 64'd1;
    end
  endfunction

  // One range pair of a query: validate, cut at the exec point, watch and sum
  function automatic void add_pair(logic [31:0] addr, logic [31:0] len, logic [31:0] pc);
    logic [31:0] at, phys;
    int          p, last;
    at   = pc & ADDR_MASK;
    phys = addr & ADDR_MASK;
    if (q_failed) return;
    if (!win_valid || len == 0 || phys < win_lo || phys >= win_hi ||
        len > win_hi - phys) begin
      q_failed = 1'b1;
      return;
    end
    if (phys + len <= at) return;
    if (phys < at) begin
      len  = len - (at - phys);
      phys = at;
    end
    q_any = 1'b1;
    last  = int'((phys + len - 32'd1) >> PAGE_SHIFT);
    for (p = int'(phys >> PAGE_SHIFT); p <= last && p < PAGE_COUNT; p++) begin
      watched[p] = 1'b1;
      if (GEN_MAX - run_sum < page_gen[p]) q_repr = 1'b0;
      else run_sum = run_sum + page_gen[p];
    end
  endfunction

  // Answers first, then the new item: an item never answers at its own edge
  always @(posedge clk_i or negedge rst_ni) begin
    pgwt_out_t want;
    bit        ok;
    int        errs;
    if (!rst_ni) begin
      foreach (page_gen[p]) begin
        page_gen[p] = '0;
        watched[p]  = 1'b0;
      end
      epoch     = 64'd1;
      win_lo    = '0;
      win_hi    = '0;
      win_valid = 1'b0;
      disabled  = 1'b0;
      clear_query();
      pending_answers.delete();
      fail_count_o   <= 0;
      answer_count_o <= 0;
    end else begin
      errs = 0;
      if (out_valid_i && !out_stall_i) begin
        answer_count_o <= answer_count_o + 1;
        if (pending_answers.size() == 0) begin
          $error("unexpected answer: cacheable %0b epoch %0h sum %0h",
                 out_i.cacheable, out_i.cache_epoch, out_i.generation_sum);
          errs++;
        end else begin
          want = pending_answers.pop_front();
          if (out_i.cacheable !== want.cacheable) begin
            $error("cacheable: expected %0b, got %0b", want.cacheable, out_i.cacheable);
            errs++;
          end
          if (out_i.cache_epoch !== want.cache_epoch) begin
            $error("cache_epoch: expected %0h, got %0h", want.cache_epoch,
                   out_i.cache_epoch);
            errs++;
          end
          if (out_i.generation_sum !== want.generation_sum) begin
            $error("generation_sum: expected %0h, got %0h", want.generation_sum,
                   out_i.generation_sum);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      if (in_valid_i && !in_stall_i) begin
        case (in_i.operation)
          OP_RESET:    restart_image(in_i.drop_watches);
          OP_REGISTER: set_window(in_i.address, in_i.length);
          OP_WRITE:    note_write(in_i.address, in_i.length);
          default: begin
            add_pair(in_i.address, in_i.length, in_i.exec_pc);
            if (in_i.last_pair) begin
              ok = !q_failed && q_any && q_repr && !disabled;
              want.cacheable      = ok;
              want.cache_epoch    = ok ? epoch : 64'd0;
              want.generation_sum = ok ? run_sum : 64'd0;
              pending_answers.push_back(want);
              clear_query();
            end
          end
        endcase
      end
    end
  end

endmodule

[bench/tb_page_generation_write_tracker.sv]
// Testbench top for the page generation write tracker.
// Makes directed and random item streams and gives the verdict; needs
// pgwt_pkg, the tracker RTL and pgwt_result_checker.
`timescale 1ns / 100ps
module tb_page_generation_write_tracker;
  import pgwt_pkg::*;

  localparam int          PAGE_SHIFT = 12;
  localparam int          PAGE_COUNT = 512;
  localparam int unsigned PG         = 1 << PAGE_SHIFT;
  localparam int unsigned RAM_BYTES  = PAGE_COUNT << PAGE_SHIFT;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  pgwt_in_t  in_item;
  pgwt_out_t out_item;

  int fail_count, pending_count, answer_count;
  int items_sent, lists_sent, windows_set;
  int stall_left;
  logic [15:0] cyc;
  logic quiet;
  int unsigned win_lo, win_hi;

  page_generation_write_tracker #(
    .PAGE_SHIFT(PAGE_SHIFT),
    .PAGE_COUNT(PAGE_COUNT)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_item)
  );

  pgwt_result_checker #(
    .PAGE_SHIFT(PAGE_SHIFT),
    .PAGE_COUNT(PAGE_COUNT)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_i           (in_item),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_i          (out_item),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count),
    .answer_count_o (answer_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stretches with no idling on either side
  assign quiet = (cyc[11:10] == 2'b00);

  // Receiver stall: mostly short bursts, a few long ones
  always @(posedge clk or negedge rst_n) begin
    int r;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      cyc        <= '0;
    end else begin
      cyc <= cyc + 16'd1;
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (quiet || r < 65) begin
        out_stall <= 1'b0;
      end else if (r < 95) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input pgwt_in_t it);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_op(input pgwt_op_e op, input logic [31:0] addr, input logic [31:0] len,
                         input logic clr, input logic [31:0] pc, input logic last);
    pgwt_in_t it;
    it.operation     = op;
    it.address       = addr;
    it.length        = len;
    it.drop_watches  = clr;
    it.exec_pc       = pc;
    it.last_pair     = last;
    if (op == OP_REGISTER) begin
      windows_set++;
      // Stimulus-side note of the window, only to aim pairs and writes
      if (addr >= RAM_BYTES) begin
        win_lo = 0;
        win_hi = 0;
      end else begin
        win_lo = addr;
        win_hi = (len > RAM_BYTES - addr) ? RAM_BYTES : addr + len;
      end
    end
    if (op == OP_PAIR && last) lists_sent++;
    send_item(it);
  endtask

  // Random content on fields the operation does not use
  function automatic logic [31:0] junk();
    return $urandom();
  endfunction

  task automatic random_write();
    int unsigned span, addr, len;
    span = win_hi - win_lo;
    if (span == 0) addr = $urandom_range(0, RAM_BYTES - 1);
    else addr = win_lo + ($urandom() % (span + 2 * PG)) - PG;
    len = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 3 * PG);
    send_op(OP_WRITE, addr, len, 1'($urandom_range(0, 1)), junk(),
            1'($urandom_range(0, 1)));
  endtask

  task automatic random_query();
    int          n, i;
    int unsigned span, start, len, pc;
    logic [31:0] addr;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      span = win_hi - win_lo;
      if (span != 0 && $urandom_range(0, 99) < 85) begin
        start = win_lo + $urandom() % span;
        len   = $urandom_range(1, (win_hi - start < 3 * PG) ? win_hi - start : 3 * PG);
      end else begin
        start = $urandom_range(0, RAM_BYTES + PG);
        len   = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2 * PG);
      end
      // High address bits are masked off by the block
      addr = start | ($urandom_range(0, 7) << 29);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: pc = 0;
        5, 6, 7:       pc = start + $urandom_range(0, len);
        default:       pc = $urandom();
      endcase
      send_op(OP_PAIR, addr, len, 1'($urandom_range(0, 1)), pc, i == n - 1);
      // Now and then another operation lands inside an open query
      if (i != n - 1 && $urandom_range(0, 19) == 0) random_write();
    end
  endtask

  task automatic random_window();
    int unsigned lo, len;
    lo  = $urandom_range(0, RAM_BYTES - 1);
    if ($urandom_range(0, 1) == 0) lo = lo & ~(PG - 1);
    len = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(1, 16 * PG);
    send_op(OP_REGISTER, lo, len, 1'($urandom_range(0, 1)), junk(),
            1'($urandom_range(0, 1)));
  endtask

  initial begin
    pgwt_in_t     noise;
    logic [159:0] raw;
    int           r, waited;
    bit           paused;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_item    <= '0;
    items_sent  = 0;
    lists_sent  = 0;
    windows_set = 0;
    win_lo      = 0;
    win_hi      = 0;
    paused      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unregistered image, clipping, exec point cuts, failed queries
    send_op(OP_WRITE, 32'h1000, 32'h100, 1'b0, 32'h0, 1'b0);
    send_op(OP_PAIR, 32'h1000, 32'h100, 1'b0, 32'h0, 1'b1);
    send_op(OP_REGISTER, 32'h1800, 32'h8000, 1'b0, 32'h0, 1'b0);
    send_op(OP_PAIR, 32'h1800, 32'h3000, 1'b0, 32'h0, 1'b0);
    send_op(OP_PAIR, 32'hE000_2000, 32'h100, 1'b0, 32'h0, 1'b1);
    send_op(OP_WRITE, 32'h0, 32'h3000, 1'b0, 32'h0, 1'b0);
    send_op(OP_WRITE, 32'h2000, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    send_op(OP_PAIR, 32'h1800, 32'h4000, 1'b0, 32'h2800, 1'b1);
    send_op(OP_PAIR, 32'h1800, 32'h100, 1'b0, 32'h5000, 1'b1);
    send_op(OP_PAIR, 32'h4000, 32'h0, 1'b0, 32'h0, 1'b0);
    send_op(OP_PAIR, 32'h2000, 32'h10, 1'b0, 32'h0, 1'b0);
    send_op(OP_WRITE, 32'h2000, 32'h1, 1'b0, 32'h0, 1'b0);
    send_op(OP_PAIR, 32'h2000, 32'h10, 1'b0, 32'h0, 1'b1);
    send_op(OP_RESET, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0);
    send_op(OP_WRITE, 32'h2000, 32'h4, 1'b0, 32'h0, 1'b0);
    send_op(OP_PAIR, 32'h2000, 32'h100, 1'b0, 32'h0, 1'b1);
    send_op(OP_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_op(OP_REGISTER, 32'h1F_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    send_op(OP_PAIR, 32'h1F_FFFF, 32'h1, 1'b0, 32'hFFFF_FFFF, 1'b1);
    send_op(OP_PAIR, 32'h1F_FFFF, 32'h2, 1'b0, 32'h0, 1'b1);
    send_op(OP_REGISTER, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0);
    send_op(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_op(OP_REGISTER, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    send_op(OP_PAIR, 32'h0, 32'h1000, 1'b0, 32'h0, 1'b1);

    // Random: windows, writes into them and query lists, plus some noise
    while (items_sent < 1125) begin
      if (!paused && items_sent > 600) begin
        // Hold the sender until every pending answer is out
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 8 || win_hi == win_lo) random_window();
      else if (r < 45) random_write();
      else if (r < 88) random_query();
      else if (r < 93) send_op(OP_RESET, junk(), junk(), 1'($urandom_range(0, 1)), junk(),
                               1'($urandom_range(0, 1)));
      else begin
        raw   = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        noise = raw[$bits(pgwt_in_t)-1:0];
        if (noise.operation == OP_REGISTER) windows_set++;
        send_item(noise);
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for a trailing reset sweep
    waited = 0;
    while (pending_count != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (1500) @(posedge clk);

    $display("Ran %0d items: %0d query lists, %0d image registrations.",
             items_sent, lists_sent, windows_set);
    $display("Checked %0d answers, %0d still pending, %0d failures.",
             answer_count, pending_count, fail_count);
    if (fail_count == 0 && pending_count == 0)
      $display("** page_generation_write_tracker: PASSED **");
    else
      $display("** page_generation_write_tracker: FAILED **");
    $finish;
  end

  // Run limit
  initial begin
    #(10_000_000 * 12);
    $display("Run limit reached.");
    $display("** page_generation_write_tracker: FAILED **");
    $finish;
  end

endmodule
